[rtl/bfsw_pkg.sv]
package bfsw_pkg;

  localparam int TAPS        = 27;
  localparam int CENTER_TAP  = 13;
  localparam int LAST_TAP    = 26;
  localparam int WIDTH_W     = 16;
  localparam int MASK_W      = 27;
  localparam int PROD_W      = 2 * WIDTH_W;
  localparam int VOL_W       = 3 * WIDTH_W + 3;
  localparam int TOTAL_W     = VOL_W + 5;
  localparam int REM_W       = TOTAL_W + 1;
  localparam int WEIGHT_W    = 17;
  localparam int TAP_W       = 5;
  localparam int DIV_STEPS   = WEIGHT_W;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);

  typedef logic [1:0] digit_t;

  typedef struct packed {
    logic [2:0][WIDTH_W-1:0] wx;
    logic [2:0][WIDTH_W-1:0] wy;
    logic [2:0][WIDTH_W-1:0] wz;
    logic [MASK_W-1:0]       flow;
    logic [MASK_W-1:0]       idx;
  } cell_t;

  typedef struct packed {
    cell_t              geom;
    logic [TOTAL_W-1:0] total;
    logic               corner;
    logic               center_flow;
  } job_t;

  typedef enum logic [1:0] {
    W_ZERO,
    W_ONE,
    W_DIV
  } wsel_t;

  function automatic logic [TAP_W-1:0] tap_pos(digit_t z, digit_t y, digit_t x);
    return TAP_W'({z, 3'b000}) + TAP_W'(z) + TAP_W'({y, 1'b0}) + TAP_W'(y) + TAP_W'(x);
  endfunction

  // Halve once per nonzero offset; corners keep the full product.
  function automatic logic [1:0] vol_shift(digit_t z, digit_t y, digit_t x, logic corner);
    logic [1:0] nz;
    nz = 2'(x != 2'd1) + 2'(y != 2'd1) + 2'(z != 2'd1);
    return corner ? 2'd3 : 2'd3 - nz;
  endfunction

  // Exactly three of the six face neighbours are not flow cells.
  function automatic logic is_corner(logic [MASK_W-1:0] flow);
    logic [2:0] n;
    n = 3'(!flow[14]) + 3'(!flow[12]) + 3'(!flow[16]) +
        3'(!flow[10]) + 3'(!flow[22]) + 3'(!flow[4]);
    return n == 3'd3;
  endfunction

endpackage

[rtl/bfsw_front.sv]
module bfsw_front #(
  parameter int DEPTH = bfsw_pkg::QUEUE_DEPTH,
  parameter int LW    = $clog2(DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  bfsw_pkg::cell_t cell_in,
  output logic            busy,
  input  logic [LW-1:0]   q_level,
  output logic            push,
  output bfsw_pkg::job_t  push_job
);

  bfsw_pkg::cell_t item, pend;
  logic active;
  bfsw_pkg::digit_t x, y, z;
  logic [LW-1:0] inflight;
  logic last_issue, accept;

  logic s1_valid, s1_first, s1_last, s1_used;
  logic [bfsw_pkg::PROD_W-1:0] s1_prod;
  logic [bfsw_pkg::WIDTH_W-1:0] s1_wz;
  logic [1:0] s1_sh;
  logic s2_valid, s2_first, s2_last;
  logic [bfsw_pkg::VOL_W-1:0] s2_term;
  logic [bfsw_pkg::TOTAL_W-1:0] acc, acc_sum;
  logic [bfsw_pkg::TAP_W-1:0] tap;

  assign tap        = bfsw_pkg::tap_pos(z, y, x);
  assign last_issue = active && (tap == bfsw_pkg::TAP_W'(bfsw_pkg::LAST_TAP));
  assign busy       = (active && !last_issue) ||
                      ((LW + 1)'(q_level) + (LW + 1)'(inflight) >= (LW + 1)'(DEPTH));
  assign accept     = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      inflight <= '0;
    end else begin
      if (accept) begin
        active <= 1'b1;
      end else if (last_issue) begin
        active <= 1'b0;
      end
      inflight <= inflight + LW'(accept) - LW'(push);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= cell_in;
      x <= '0;
      y <= '0;
      z <= '0;
    end else if (active) begin
      if (x == 2'd2) begin
        x <= '0;
        if (y == 2'd2) begin
          y <= '0;
          z <= z + 2'd1;
        end else begin
          y <= y + 2'd1;
        end
      end else begin
        x <= x + 2'd1;
      end
    end
    if (last_issue) begin
      pend <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= active;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_prod  <= bfsw_pkg::PROD_W'(item.wx[x] * item.wy[y]);
    s1_wz    <= item.wz[z];
    s1_sh    <= bfsw_pkg::vol_shift(z, y, x, bfsw_pkg::is_corner(item.flow));
    s1_used  <= item.flow[tap] && item.idx[tap];
    s1_first <= tap == '0;
    s1_last  <= last_issue;
    s2_term  <= s1_used ?
                bfsw_pkg::VOL_W'(bfsw_pkg::VOL_W'(s1_prod * s1_wz) << s1_sh) : '0;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    if (s2_valid) begin
      acc <= acc_sum;
    end
  end

  assign acc_sum = (s2_first ? '0 : acc) + bfsw_pkg::TOTAL_W'(s2_term);

  assign push                 = s2_valid && s2_last;
  assign push_job.geom        = pend;
  assign push_job.total       = acc_sum;
  assign push_job.corner      = bfsw_pkg::is_corner(pend.flow);
  assign push_job.center_flow = pend.flow[bfsw_pkg::CENTER_TAP];

endmodule

[rtl/bfsw_queue.sv]
module bfsw_queue #(
  parameter int DEPTH = bfsw_pkg::QUEUE_DEPTH,
  parameter int LW    = $clog2(DEPTH + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bfsw_pkg::job_t push_job,
  input  logic           pop,
  output logic           q_valid,
  output bfsw_pkg::job_t q_job,
  output logic [LW-1:0]  level
);

  localparam int AW = $clog2(DEPTH);

  bfsw_pkg::job_t slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      level <= level + LW'(push) - LW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  assign q_valid = level != '0;
  assign q_job   = slots[rd_ptr];

endmodule

[rtl/bfsw_back.sv]
module bfsw_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  bfsw_pkg::job_t                 q_job,
  output logic                           pop,
  output logic                           strobe,
  output logic [bfsw_pkg::TAP_W-1:0]     tap_index,
  output logic [bfsw_pkg::WEIGHT_W-1:0]  weight,
  output logic                           last_tap
);

  localparam int N = bfsw_pkg::DIV_STEPS;
  localparam int RW = bfsw_pkg::REM_W;
  localparam int TW = bfsw_pkg::TAP_W;
  localparam int QW = bfsw_pkg::WEIGHT_W;

  bfsw_pkg::job_t job;
  logic active, last_issue;
  bfsw_pkg::digit_t x, y, z;
  logic [TW-1:0] tap;
  bfsw_pkg::wsel_t sel;

  logic m1_valid, m1_last;
  logic [bfsw_pkg::PROD_W-1:0] m1_prod;
  logic [bfsw_pkg::WIDTH_W-1:0] m1_wz;
  logic [1:0] m1_sh;
  logic [TW-1:0] m1_tap;
  bfsw_pkg::wsel_t m1_sel;
  logic [bfsw_pkg::TOTAL_W-1:0] m1_total;

  logic m2_valid, m2_last;
  logic [bfsw_pkg::VOL_W-1:0] m2_vol;
  logic [TW-1:0] m2_tap;
  bfsw_pkg::wsel_t m2_sel;
  logic [bfsw_pkg::TOTAL_W-1:0] m2_total;

  logic            dv    [N];
  logic            dlast [N];
  logic [RW-1:0]   dr    [N];
  logic [QW-1:0]   dq    [N];
  logic [RW-1:0]   dden  [N];
  logic [TW-1:0]   dtap  [N];
  bfsw_pkg::wsel_t dsel  [N];

  assign tap        = bfsw_pkg::tap_pos(z, y, x);
  assign last_issue = active && (tap == TW'(bfsw_pkg::LAST_TAP));
  assign pop        = q_valid && (!active || last_issue);

  always_comb begin
    if (!job.center_flow) begin
      sel = (tap == TW'(bfsw_pkg::CENTER_TAP)) ? bfsw_pkg::W_ONE : bfsw_pkg::W_ZERO;
    end else if (job.geom.flow[tap] && job.geom.idx[tap] && job.total != '0) begin
      sel = bfsw_pkg::W_DIV;
    end else begin
      sel = bfsw_pkg::W_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (pop) begin
      active <= 1'b1;
    end else if (last_issue) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= q_job;
      x <= '0;
      y <= '0;
      z <= '0;
    end else if (active) begin
      if (x == 2'd2) begin
        x <= '0;
        if (y == 2'd2) begin
          y <= '0;
          z <= z + 2'd1;
        end else begin
          y <= y + 2'd1;
        end
      end else begin
        x <= x + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
    end else begin
      m1_valid <= active;
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    m1_prod  <= bfsw_pkg::PROD_W'(job.geom.wx[x] * job.geom.wy[y]);
    m1_wz    <= job.geom.wz[z];
    m1_sh    <= bfsw_pkg::vol_shift(z, y, x, job.corner);
    m1_tap   <= tap;
    m1_last  <= last_issue;
    m1_sel   <= sel;
    m1_total <= job.total;
    m2_vol   <= bfsw_pkg::VOL_W'(bfsw_pkg::VOL_W'(m1_prod * m1_wz) << m1_sh);
    m2_tap   <= m1_tap;
    m2_last  <= m1_last;
    m2_sel   <= m1_sel;
    m2_total <= m1_total;
  end

  // Restoring divider, one quotient bit per stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (RW'(m2_vol) >= RW'(m2_total)) begin
      dr[0] <= RW'(m2_vol) - RW'(m2_total);
      dq[0] <= QW'(1);
    end else begin
      dr[0] <= RW'(m2_vol);
      dq[0] <= '0;
    end
    dden[0]  <= RW'(m2_total);
    dtap[0]  <= m2_tap;
    dlast[0] <= m2_last;
    dsel[0]  <= m2_sel;
  end

  for (genvar k = 1; k < N; k++) begin : g_div
    logic [RW-1:0] r2;
    logic ge;
    assign r2 = {dr[k-1][RW-2:0], 1'b0};
    assign ge = r2 >= dden[k-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else begin
        dv[k] <= dv[k-1];
      end
    end

    always_ff @(posedge clk) begin
      dr[k]    <= ge ? r2 - dden[k-1] : r2;
      dq[k]    <= {dq[k-1][QW-2:0], ge};
      dden[k]  <= dden[k-1];
      dtap[k]  <= dtap[k-1];
      dlast[k] <= dlast[k-1];
      dsel[k]  <= dsel[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= dv[N-1];
    end
  end

  always_ff @(posedge clk) begin
    tap_index <= dtap[N-1];
    last_tap  <= dlast[N-1];
    case (dsel[N-1])
      bfsw_pkg::W_ONE: weight <= bfsw_pkg::WEIGHT_ONE;
      bfsw_pkg::W_DIV: weight <= dq[N-1];
      default:         weight <= '0;
    endcase
  end

  a_last_tap: assert property (@(posedge clk) disable iff (rst)
    strobe && last_tap |-> tap_index == TW'(bfsw_pkg::LAST_TAP))
    else $error("last tap flag on wrong tap");

  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> weight <= bfsw_pkg::WEIGHT_ONE)
    else $error("weight above one");

  a_tap_order: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_tap |=> strobe && tap_index == TW'($past(tap_index) + TW'(1)))
    else $error("taps of a cell not contiguous");

endmodule

[rtl/box_filter_stencil_weights.sv]
// Channel   Ports                                        Transfer
// --------  -------------------------------------------  ----------------------------
// cell in   start, busy, width_{x,y,z}_{minus,mid,plus},  start high and busy low
//           flow_mask, indexed_mask
// taps out  strobe, tap_index, weight, last_tap           every cycle strobe is high
//
// One cell yields 27 taps, one per cycle, so a new cell is taken at best as the
// previous one issues its last tap; the single result port sets that limit. From
// transfer to the first tap, the front issues all taps and finishes the sum, the job
// passes the queue, then the multiply stages, 17 divider stages and the output register.
// Reset (rst, synchronous) empties the queue and pipelines.
// The receiver cannot stall; busy alone holds the sender off.
module box_filter_stencil_weights #(
  parameter int QUEUE_DEPTH = bfsw_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bfsw_pkg::WIDTH_W-1:0]  width_x_minus,
  input  logic [bfsw_pkg::WIDTH_W-1:0]  width_x_mid,
  input  logic [bfsw_pkg::WIDTH_W-1:0]  width_x_plus,
  input  logic [bfsw_pkg::WIDTH_W-1:0]  width_y_minus,
  input  logic [bfsw_pkg::WIDTH_W-1:0]  width_y_mid,
  input  logic [bfsw_pkg::WIDTH_W-1:0]  width_y_plus,
  input  logic [bfsw_pkg::WIDTH_W-1:0]  width_z_minus,
  input  logic [bfsw_pkg::WIDTH_W-1:0]  width_z_mid,
  input  logic [bfsw_pkg::WIDTH_W-1:0]  width_z_plus,
  input  logic [bfsw_pkg::MASK_W-1:0]   flow_mask,
  input  logic [bfsw_pkg::MASK_W-1:0]   indexed_mask,
  output logic                          strobe,
  output logic [bfsw_pkg::TAP_W-1:0]    tap_index,
  output logic [bfsw_pkg::WEIGHT_W-1:0] weight,
  output logic                          last_tap
);

  localparam int LW = $clog2(QUEUE_DEPTH + 1);

  bfsw_pkg::cell_t cell_in;
  bfsw_pkg::job_t  push_job, q_job;
  logic            push, pop, q_valid;
  logic [LW-1:0]   q_level;

  // Gather the widths by axis, index 0 at offset -1.
  assign cell_in.wx   = {width_x_plus, width_x_mid, width_x_minus};
  assign cell_in.wy   = {width_y_plus, width_y_mid, width_y_minus};
  assign cell_in.wz   = {width_z_plus, width_z_mid, width_z_minus};
  assign cell_in.flow = flow_mask;
  assign cell_in.idx  = indexed_mask;

  // Front: sum the counted tap volumes of a cell, one tap a cycle.
  bfsw_front #(.DEPTH(QUEUE_DEPTH), .LW(LW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cell_in  (cell_in),
    .busy     (busy),
    .q_level  (q_level),
    .push     (push),
    .push_job (push_job)
  );

  // Hold finished totals so front and back advance independently.
  bfsw_queue #(.DEPTH(QUEUE_DEPTH), .LW(LW)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .level    (q_level)
  );

  // Back: recompute each volume, divide by the total, emit one tap a cycle.
  bfsw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .strobe    (strobe),
    .tap_index (tap_index),
    .weight    (weight),
    .last_tap  (last_tap)
  );

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [bfsw_pkg::WIDTH_W-1:0] width_x_minus = '0, width_x_mid = '0, width_x_plus = '0;
  logic [bfsw_pkg::WIDTH_W-1:0] width_y_minus = '0, width_y_mid = '0, width_y_plus = '0;
  logic [bfsw_pkg::WIDTH_W-1:0] width_z_minus = '0, width_z_mid = '0, width_z_plus = '0;
  logic [bfsw_pkg::MASK_W-1:0] flow_mask = '0, indexed_mask = '0;
  logic strobe;
  logic [bfsw_pkg::TAP_W-1:0] tap_index;
  logic [bfsw_pkg::WEIGHT_W-1:0] weight;
  logic last_tap;

  typedef struct packed {
    logic [bfsw_pkg::TAP_W-1:0]    tap;
    logic [bfsw_pkg::WEIGHT_W-1:0] wt;
    logic                          last;
  } tap_result_t;

  tap_result_t pending_taps[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit sending_done = 1'b0;

  box_filter_stencil_weights dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Work out the 27 weights of one cell and queue them in tap order.
  task automatic predict_cell(input logic [2:0][bfsw_pkg::WIDTH_W-1:0] wx, wy, wz,
                              input logic [bfsw_pkg::MASK_W-1:0] flow, idx);
    logic [bfsw_pkg::VOL_W-1:0]    vol[bfsw_pkg::TAPS];
    logic [bfsw_pkg::TOTAL_W-1:0]  total;
    logic [bfsw_pkg::REM_W-1:0]    rem;
    logic [bfsw_pkg::WEIGHT_W-1:0] q;
    int nfaces, nz, sh, ix, iy, iz;
    bit corner, used;
    tap_result_t r;
    nfaces = int'(!flow[14]) + int'(!flow[12]) + int'(!flow[16]) +
             int'(!flow[10]) + int'(!flow[22]) + int'(!flow[4]);
    corner = (nfaces == 3);
    total = '0;
    for (int t = 0; t < bfsw_pkg::TAPS; t++) begin
      ix = t % 3; iy = (t / 3) % 3; iz = t / 9;
      nz = int'(ix != 1) + int'(iy != 1) + int'(iz != 1);
      sh = corner ? 3 : 3 - nz;
      vol[t] = (bfsw_pkg::VOL_W'(wx[ix]) * bfsw_pkg::VOL_W'(wy[iy]) *
                bfsw_pkg::VOL_W'(wz[iz])) << sh;
      if (flow[t] && idx[t]) total += bfsw_pkg::TOTAL_W'(vol[t]);
    end
    for (int t = 0; t < bfsw_pkg::TAPS; t++) begin
      used = flow[t] && idx[t];
      if (!flow[bfsw_pkg::CENTER_TAP])
        q = (t == bfsw_pkg::CENTER_TAP) ? bfsw_pkg::WEIGHT_ONE : '0;
      else if (!used || total == '0) q = '0;
      else begin
        // restoring division, exact floor(vol * 2^16 / total)
        rem = bfsw_pkg::REM_W'(vol[t]);
        q = '0;
        if (rem >= total) begin q = bfsw_pkg::WEIGHT_W'(1); rem -= total; end
        for (int i = 0; i < 16; i++) begin
          rem = rem << 1;
          q = q << 1;
          if (rem >= total) begin rem -= total; q[0] = 1'b1; end
        end
      end
      r.tap = bfsw_pkg::TAP_W'(t);
      r.wt = q;
      r.last = (t == bfsw_pkg::LAST_TAP);
      pending_taps.push_back(r);
    end
  endtask

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 3);
  endfunction

  // Drop start for an optional gap, then hold it until the transfer.
  task automatic send_cell(input logic [2:0][bfsw_pkg::WIDTH_W-1:0] wx, wy, wz,
                           input logic [bfsw_pkg::MASK_W-1:0] flow, idx, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
    start <= 1'b1;
    {width_x_plus, width_x_mid, width_x_minus} <= wx;
    {width_y_plus, width_y_mid, width_y_minus} <= wy;
    {width_z_plus, width_z_mid, width_z_minus} <= wz;
    flow_mask <= flow;
    indexed_mask <= idx;
    do @(posedge clk); while (busy);
    predict_cell(wx, wy, wz, flow, idx);
  endtask

  function automatic logic [bfsw_pkg::WIDTH_W-1:0] rand_width();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return bfsw_pkg::WIDTH_W'($urandom_range(1, 16));
      default: return bfsw_pkg::WIDTH_W'($urandom);
    endcase
  endfunction

  function automatic logic [bfsw_pkg::MASK_W-1:0] rand_mask(input bit dense);
    logic [bfsw_pkg::MASK_W-1:0] m;
    m = bfsw_pkg::MASK_W'($urandom);
    if (dense) m |= bfsw_pkg::MASK_W'($urandom) | bfsw_pkg::MASK_W'($urandom);
    return m;
  endfunction

  task automatic test_directed();
    logic [2:0][bfsw_pkg::WIDTH_W-1:0] ones, maxw, zero;
    ones = {3{16'h0100}};
    maxw = {3{16'hFFFF}};
    zero = '0;
    send_cell(ones, ones, ones, '1, '1, 1'b0);
    send_cell(maxw, maxw, maxw, '1, '1, 1'b0);
    send_cell(maxw, maxw, maxw, '1, '0, 1'b0);               // zero total
    send_cell(zero, zero, zero, '1, '1, 1'b0);               // all zero widths
    send_cell(ones, ones, ones, ~(27'd1 << bfsw_pkg::CENTER_TAP), '1, 1'b0); // non-flow centre
    send_cell(zero, zero, zero, '0, '0, 1'b0);               // non-flow centre, zero volume
    // corner: three face neighbours not flow
    send_cell(ones, ones, ones, ~((27'd1 << 14) | (27'd1 << 16) | (27'd1 << 22)), '1, 1'b0);
    send_cell(maxw, maxw, maxw, ~((27'd1 << 12) | (27'd1 << 10) | (27'd1 << 4)), '1, 1'b0);
    // two and four non-flow faces: not corners
    send_cell(ones, ones, ones, ~((27'd1 << 14) | (27'd1 << 12)), '1, 1'b0);
    send_cell(ones, ones, ones, ~(27'h1 << 14 | 27'h1 << 12 | 27'h1 << 16 | 27'h1 << 10),
              '1, 1'b0);
    send_cell(ones, ones, ones, 27'd1 << bfsw_pkg::CENTER_TAP,
              27'd1 << bfsw_pkg::CENTER_TAP, 1'b0);          // centre only
    send_cell({16'h0001, 16'hFFFF, 16'h0001}, {16'h0001, 16'hFFFF, 16'h0001},
              {16'h0001, 16'hFFFF, 16'h0001}, '1, '1, 1'b0);
    send_cell({16'hFFFF, 16'h0001, 16'hFFFF}, {16'hFFFF, 16'h0001, 16'hFFFF},
              {16'hFFFF, 16'h0001, 16'hFFFF}, 27'h5555555, 27'h2AAAAAA | 27'h2000, 1'b0);
  endtask

  task automatic test_random();
    logic [2:0][bfsw_pkg::WIDTH_W-1:0] wx, wy, wz;
    logic [bfsw_pkg::MASK_W-1:0] flow, idx;
    int kind;
    for (int n = 0; n < 400; n++) begin
      for (int a = 0; a < 3; a++) begin
        wx[a] = rand_width(); wy[a] = rand_width(); wz[a] = rand_width();
      end
      kind = $urandom_range(0, 9);
      flow = rand_mask(kind < 7);
      idx = rand_mask(kind < 7);
      if (kind < 6) flow[bfsw_pkg::CENTER_TAP] = 1'b1;
      if (kind == 3) begin
        // force a corner
        flow[14] = 1'b1; flow[12] = 1'b1; flow[16] = 1'b1;
        flow[10] = 1'b1; flow[22] = 1'b1; flow[4] = 1'b1;
        flow[$urandom_range(0, 1) ? 14 : 12] = 1'b0;
        flow[$urandom_range(0, 1) ? 16 : 10] = 1'b0;
        flow[$urandom_range(0, 1) ? 22 : 4] = 1'b0;
      end
      send_cell(wx, wy, wz, flow, idx, n % 50 >= 10);
    end
  endtask

  // Compare every tap against the oldest prediction.
  always @(posedge clk) begin
    tap_result_t want;
    if (!rst && strobe) begin
      if (pending_taps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected tap %0d weight %0d", tap_index, weight);
      end else begin
        want = pending_taps.pop_front();
        if (want.tap !== tap_index || want.wt !== weight || want.last !== last_tap) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tap mismatch: want %0d/%0d/%0d got %0d/%0d/%0d",
                     want.tap, want.wt, want.last, tap_index, weight, last_tap);
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on either side.
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy) || (sending_done && pending_taps.size() == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    start <= 1'b0;
    sending_done = 1'b1;
    while (pending_taps.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_taps.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
